@@ design/okl_pkg.sv @@
// Shared constants, codes and types for the ordered keyed list engine.
// No dependencies; the engine top level and the checker import this package.
`timescale 1ns / 1ps

package okl_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 64;

  localparam int KEY_W  = 64;
  localparam int POS_W  = 8;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int SLOT_W = 7;
  localparam int NOW_W  = 7;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ENT_W  = 2 * KEY_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_POP      = 3'd3,
    OP_SEARCH   = 3'd4,
    OP_SORT     = 3'd5,
    OP_READ_ALL = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] name;
  } entry_t;

endpackage

@@ design/okl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; the read data holds its value while no read is issued.
`timescale 1ns / 1ps

module okl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ordered_keyed_list_engine_unit.sv @@
// Top level of the ordered keyed list engine: sequencer, shared comparator
// and output register. Depends on okl_pkg and one okl_ram instance.
`timescale 1ns / 1ps

// The block keeps an ordered list of up to CAPACITY entries, each a 64-bit
// key and a 64-bit name, held in a single RAM with one write and one
// registered read port. A command item enters on the input channel
// (in_valid_i / in_stall_o) and produces one or more result items on the
// output channel (out_valid_o / out_stall_i); the final result of a command
// carries last_o.
// Every entry visit first issues the RAM read and then evaluates the data,
// and all compares go through one shared 64-bit unit. Append and insert
// scan every stored entry for a duplicate key, insert then shifts each
// entry at or above the target up by one, delete and pop move the entries
// above the removed one down, search and read all visit every entry, and
// the sort is a bubble sort. A full list, an empty list or a bad position
// is answered without a scan; a duplicate key is only found by the scan.
// The block takes one command at a time: in_stall_o is high from the cycle
// after an item is accepted until its final result has been loaded into the
// output register. That register lets the next command be accepted while
// the last result still waits.
// When the receiver stalls, the result is held unchanged and the sequencer
// waits at its next result, so no result is ever lost or repeated.
// Reset empties the list by clearing the entry count; the RAM contents are
// not cleared, as only entries below the count are ever read.

module ordered_keyed_list_engine_unit
  import okl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [KEY_W-1:0]  entry_key_i,
  input  logic [KEY_W-1:0]  entry_name_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ST_W-1:0]   status_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [KEY_W-1:0]  out_name_o,
  output logic [NOW_W-1:0]  entries_now_o,
  output logic              last_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_EV,
    S_PLACE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_DEL_RD0,
    S_DEL_CAP,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_DONE,
    S_SRCH_RD,
    S_SRCH_EV,
    S_SRCH_END,
    S_SORT_LD,
    S_SORT_CAP,
    S_SORT_RD,
    S_SORT_EV,
    S_SORT_END,
    S_RDA_RD,
    S_RDA_EV,
    S_REPLY
  } state_e;

  state_e state_q, state_d;

  // Control state.
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;

  // Working registers of the current command.
  op_e              op_q;
  logic [POS_W-1:0] pos_q;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] name_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  entry_t           car_q, car_d;
  status_e          rep_q, rep_d;

  // Output register payload.
  status_e           st_q;
  logic [SLOT_W-1:0] slot_q;
  entry_t            oent_q;
  logic [NOW_W-1:0]  now_q;
  logic              last_q;

  // RAM port.
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [ENT_W-1:0]  rd_raw;
  entry_t            rd_ent;

  // Result produced this cycle.
  logic             emit;
  status_e          e_st;
  logic [CNT_W-1:0] e_slot;
  entry_t           e_ent;
  logic             e_last;

  logic accept;
  logic can_emit;

  logic [CNT_W-1:0] idx_p1, idx_p2, idx_m1;
  logic [CNT_W-1:0] tgt;
  logic [CMP_W-1:0] pos_x, pin_x, cnt_x, clamp_x;

  // Shared comparator.
  logic [KEY_W-1:0] cmp_a, cmp_b;
  logic             cmp_eq, cmp_gt;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign can_emit = !out_valid_q || !out_stall_i;

  assign idx_p1 = idx_q + CNT_W'(1);
  assign idx_p2 = idx_q + CNT_W'(2);
  assign idx_m1 = idx_q - CNT_W'(1);

  assign rd_ent = rd_raw;

  // Insertion point: position clamped to 1..count, an empty list taking 1.
  always_comb begin
    pos_x   = CMP_W'(pos_q);
    pin_x   = CMP_W'(position_i);
    cnt_x   = CMP_W'(cnt_q);
    clamp_x = (pos_x >= cnt_x) ? cnt_x : pos_x;
    if (clamp_x == '0) begin
      clamp_x = CMP_W'(1);
    end
    tgt = (op_q == OP_APPEND) ? cnt_q : CNT_W'(clamp_x - CMP_W'(1));
  end

  // The search compares names; the sort compares the carried key against
  // the key read back; the duplicate check compares keys.
  always_comb begin
    cmp_a = (state_q == S_SRCH_EV) ? rd_ent.name : rd_ent.key;
    if (state_q == S_SRCH_EV) begin
      cmp_b = name_q;
    end else if (state_q == S_SORT_EV) begin
      cmp_b = car_q.key;
    end else begin
      cmp_b = key_q;
    end
    cmp_eq = (cmp_a == cmp_b);
    cmp_gt = (cmp_b > cmp_a);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    car_d   = car_q;
    rep_d   = rep_q;
    we      = 1'b0;
    waddr   = idx_q[ADDR_W-1:0];
    wdata   = rd_ent;
    re      = 1'b0;
    raddr   = idx_q[ADDR_W-1:0];
    emit    = 1'b0;
    e_st    = ST_OK;
    e_slot  = '0;
    e_ent   = '0;
    e_last  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d  = '0;
          pend_d = 1'b0;
          case (op_e'(op_i))
            OP_APPEND, OP_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                rep_d   = ST_FULL;
                state_d = S_REPLY;
              end else if (cnt_q == '0) begin
                state_d = S_PLACE;
              end else begin
                state_d = S_DUP_RD;
              end
            end
            OP_DELETE, OP_POP: begin
              if (cnt_q == '0) begin
                rep_d   = ST_EMPTY;
                state_d = S_REPLY;
              end else if ((op_e'(op_i) == OP_DELETE) && (pin_x > cnt_x)) begin
                rep_d   = ST_BADPOS;
                state_d = S_REPLY;
              end else begin
                if ((op_e'(op_i) == OP_POP) || (position_i == '0)) begin
                  idx_d = '0;
                end else begin
                  idx_d = CNT_W'(pin_x - CMP_W'(1));
                end
                state_d = S_DEL_RD0;
              end
            end
            OP_SEARCH: begin
              if (cnt_q == '0) begin
                rep_d   = ST_NOTFOUND;
                state_d = S_REPLY;
              end else begin
                state_d = S_SRCH_RD;
              end
            end
            OP_SORT: begin
              if (cnt_q < CNT_W'(2)) begin
                rep_d   = ST_OK;
                state_d = S_REPLY;
              end else begin
                lim_d   = cnt_q - CNT_W'(1);
                state_d = S_SORT_LD;
              end
            end
            OP_READ_ALL: begin
              if (cnt_q == '0) begin
                rep_d   = ST_EMPTY;
                state_d = S_REPLY;
              end else begin
                state_d = S_RDA_RD;
              end
            end
            default: begin
              rep_d   = ST_OK;
              state_d = S_REPLY;
            end
          endcase
        end
      end

      // Duplicate key scan over the stored entries.
      S_DUP_RD: begin
        re      = 1'b1;
        state_d = S_DUP_EV;
      end
      S_DUP_EV: begin
        if (cmp_eq) begin
          rep_d   = ST_DUP;
          state_d = S_REPLY;
        end else if (idx_p1 == cnt_q) begin
          state_d = S_PLACE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_DUP_RD;
        end
      end

      S_PLACE: begin
        if (tgt == cnt_q) begin
          idx_d   = tgt;
          state_d = S_PUT;
        end else begin
          idx_d   = cnt_q;
          state_d = S_INS_RD;
        end
      end

      // Open a gap: move entries up by one, from the end down to the target.
      S_INS_RD: begin
        re      = 1'b1;
        raddr   = idx_m1[ADDR_W-1:0];
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        we    = 1'b1;
        idx_d = idx_m1;
        if (idx_m1 == tgt) begin
          state_d = S_PUT;
        end else begin
          state_d = S_INS_RD;
        end
      end

      S_PUT: begin
        if (can_emit) begin
          we      = 1'b1;
          wdata   = '{key: key_q, name: name_q};
          cnt_d   = cnt_q + CNT_W'(1);
          emit    = 1'b1;
          e_slot  = idx_p1;
          e_ent   = '{key: key_q, name: name_q};
          state_d = S_IDLE;
        end
      end

      // Removal: capture the entry, then close the gap from there upwards.
      S_DEL_RD0: begin
        re      = 1'b1;
        state_d = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        car_d = rd_ent;
        lim_d = idx_q;
        if (idx_p1 == cnt_q) begin
          state_d = S_DEL_DONE;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        re      = 1'b1;
        raddr   = idx_p1[ADDR_W-1:0];
        state_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        we    = 1'b1;
        idx_d = idx_p1;
        if (idx_p2 == cnt_q) begin
          state_d = S_DEL_DONE;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_DEL_DONE: begin
        if (can_emit) begin
          cnt_d   = cnt_q - CNT_W'(1);
          emit    = 1'b1;
          e_slot  = lim_q + CNT_W'(1);
          e_ent   = car_q;
          state_d = S_IDLE;
        end
      end

      // Search: one match is held back so that the final one can carry last.
      S_SRCH_RD: begin
        re      = 1'b1;
        state_d = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        if (!(cmp_eq && pend_q && !can_emit)) begin
          if (cmp_eq) begin
            if (pend_q) begin
              emit   = 1'b1;
              e_slot = lim_q + CNT_W'(1);
              e_ent  = car_q;
              e_last = 1'b0;
            end
            pend_d = 1'b1;
            car_d  = rd_ent;
            lim_d  = idx_q;
          end
          if (idx_p1 == cnt_q) begin
            state_d = S_SRCH_END;
          end else begin
            idx_d   = idx_p1;
            state_d = S_SRCH_RD;
          end
        end
      end
      S_SRCH_END: begin
        if (!pend_q) begin
          rep_d   = ST_NOTFOUND;
          state_d = S_REPLY;
        end else if (can_emit) begin
          emit    = 1'b1;
          e_slot  = lim_q + CNT_W'(1);
          e_ent   = car_q;
          state_d = S_IDLE;
        end
      end

      // Bubble sort: each pass carries the larger entry up to lim_q.
      S_SORT_LD: begin
        re      = 1'b1;
        raddr   = '0;
        idx_d   = '0;
        state_d = S_SORT_CAP;
      end
      S_SORT_CAP: begin
        car_d   = rd_ent;
        state_d = S_SORT_RD;
      end
      S_SORT_RD: begin
        re      = 1'b1;
        raddr   = idx_p1[ADDR_W-1:0];
        state_d = S_SORT_EV;
      end
      S_SORT_EV: begin
        we = 1'b1;
        if (cmp_gt) begin
          wdata = rd_ent;
        end else begin
          wdata = car_q;
          car_d = rd_ent;
        end
        idx_d = idx_p1;
        if (idx_p1 == lim_q) begin
          state_d = S_SORT_END;
        end else begin
          state_d = S_SORT_RD;
        end
      end
      S_SORT_END: begin
        we    = 1'b1;
        waddr = lim_q[ADDR_W-1:0];
        wdata = car_q;
        lim_d = lim_q - CNT_W'(1);
        if (lim_q == CNT_W'(1)) begin
          rep_d   = ST_OK;
          state_d = S_REPLY;
        end else begin
          state_d = S_SORT_LD;
        end
      end

      // Read out every entry in list order.
      S_RDA_RD: begin
        re      = 1'b1;
        state_d = S_RDA_EV;
      end
      S_RDA_EV: begin
        if (can_emit) begin
          emit   = 1'b1;
          e_slot = idx_p1;
          e_ent  = rd_ent;
          e_last = (idx_p1 == cnt_q);
          if (idx_p1 == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = S_RDA_RD;
          end
        end
      end

      S_REPLY: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_st    = rep_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      pos_q  <= position_i;
      key_q  <= entry_key_i;
      name_q <= entry_name_i;
    end
    idx_q <= idx_d;
    lim_q <= lim_d;
    car_q <= car_d;
    rep_q <= rep_d;
    if (emit) begin
      st_q   <= e_st;
      slot_q <= SLOT_W'(e_slot);
      oent_q <= e_ent;
      now_q  <= NOW_W'(cnt_d);
      last_q <= e_last;
    end
  end

  okl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = st_q;
  assign slot_o        = slot_q;
  assign out_key_o     = oent_q.key;
  assign out_name_o    = oent_q.name;
  assign entries_now_o = now_q;
  assign last_o        = last_q;

endmodule

@@ design/okl_chk.sv @@
// Port-level checker for the ordered keyed list engine, bound to the top level.
// Depends on okl_pkg and on ordered_keyed_list_engine_unit being compiled first.
`timescale 1ns / 1ps

module okl_chk
  import okl_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ST_W-1:0]   status_o,
  input logic [SLOT_W-1:0] slot_o,
  input logic [KEY_W-1:0]  out_key_o,
  input logic [KEY_W-1:0]  out_name_o,
  input logic [NOW_W-1:0]  entries_now_o,
  input logic              last_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_o) && $stable(out_key_o) && $stable(out_name_o) &&
    $stable(entries_now_o) && $stable(last_o))
    else $error("result changed while stalled");

  // A command keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a command without going busy");

  // Any failing status is a single, final result reporting no entry.
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
    last_o && (slot_o == '0) && (out_key_o == '0) && (out_name_o == '0))
    else $error("error result carries an entry or is not final");

  // The list never reports more entries than it can hold.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(entries_now_o) <= CAPACITY))
    else $error("entry count beyond capacity");

endmodule

bind ordered_keyed_list_engine_unit okl_chk u_okl_chk (.*);
